### src/mcuex_pkg.sv
// ----------------------------------------------------------------------------
// mcuex_pkg
// Shared constants and types for the mid-range instruction execute core.
// ----------------------------------------------------------------------------
`default_nettype none

package mcuex_pkg;

  localparam int unsigned PROG_WORDS_DEF  = 1024;
  localparam int unsigned STACK_DEPTH_DEF = 8;

  localparam int unsigned FILE_BYTES = 128;
  localparam int unsigned FILE_AW    = 7;
  localparam int unsigned STACK_W    = 13;

  // Status register bit positions.
  localparam int unsigned ST_C  = 0;
  localparam int unsigned ST_DC = 1;
  localparam int unsigned ST_Z  = 2;
  localparam int unsigned ST_PD = 3;
  localparam int unsigned ST_TO = 4;

  localparam logic [7:0] STATUS_RESET = 8'h18;

  typedef enum logic [1:0] {
    OUT_EXECUTED = 2'd0,
    OUT_FAULT    = 2'd1,
    OUT_HALTED   = 2'd2
  } outcome_t;

  // Byte-oriented opcode field, instruction bits 11..8.
  localparam logic [3:0] OP_MISC     = 4'h0;
  localparam logic [3:0] OP_CLR      = 4'h1;
  localparam logic [3:0] OP_SUB      = 4'h2;
  localparam logic [3:0] OP_DECF     = 4'h3;
  localparam logic [3:0] OP_OR       = 4'h4;
  localparam logic [3:0] OP_AND      = 4'h5;
  localparam logic [3:0] OP_XOR      = 4'h6;
  localparam logic [3:0] OP_ADD      = 4'h7;
  localparam logic [3:0] OP_MOVF     = 4'h8;
  localparam logic [3:0] OP_COMF     = 4'h9;
  localparam logic [3:0] OP_INCF     = 4'hA;
  localparam logic [3:0] OP_DEC_SKIP = 4'hB;
  localparam logic [3:0] OP_RRF      = 4'hC;
  localparam logic [3:0] OP_RLF      = 4'hD;
  localparam logic [3:0] OP_NIB_SWAP = 4'hE;
  localparam logic [3:0] OP_INC_SKIP = 4'hF;

  // Control words with d clear.
  localparam logic [7:0] CW_RETURN = 8'h08;
  localparam logic [7:0] CW_RETFIE = 8'h09;
  localparam logic [7:0] CW_SLEEP  = 8'h63;
  localparam logic [7:0] CW_CLRWDT = 8'h64;

  // Instruction classes, bits 13..12.
  localparam logic [1:0] GRP_BYTE = 2'b00;
  localparam logic [1:0] GRP_BIT  = 2'b01;
  localparam logic [1:0] GRP_JUMP = 2'b10;
  localparam logic [1:0] GRP_LIT  = 2'b11;

  // Bit-oriented kinds, bits 11..10.
  localparam logic [1:0] BK_BCF   = 2'd0;
  localparam logic [1:0] BK_BSF   = 2'd1;
  localparam logic [1:0] BK_BTFSC = 2'd2;
  localparam logic [1:0] BK_BTFSS = 2'd3;

endpackage

`default_nettype wire

### src/midrange_mcu_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// midrange_mcu_instruction_execute_core
// Executes one 14-bit instruction per transaction against W, STATUS, a
// 128-byte register file in synchronous RAM, the PC and a return stack.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | instruction_word
//  m_*      | out       | next_pc, w_value, status_value, outcome
//
// The register file is read and the instruction registered at the input
// transaction; the operation then executes in the execute stage, writing
// back and registering its result in the output register, from which the
// result transaction is offered. A new instruction can be taken every cycle
// while the output is not stalled; the most recent write is forwarded to
// the read that overlaps it. Reset clears the valid bits of the register file
// at once, so no clearing pass is needed. A stalled output holds the execute
// stage, which in turn holds the input.
`default_nettype none

module midrange_mcu_instruction_execute_core #(
  parameter int unsigned PROG_WORDS  = mcuex_pkg::PROG_WORDS_DEF,
  parameter int unsigned STACK_DEPTH = mcuex_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] instruction_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // [9:0] next_pc, [17:10] w_value,
                                      // [25:18] status_value, [27:26] outcome
);
  import mcuex_pkg::*;

  // PROG_WORDS is a power of two; wrapping is done by masking.
  localparam int unsigned PCW = $clog2(PROG_WORDS);
  localparam int unsigned SPW = $clog2(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

  // Architectural state.
  logic [PCW-1:0]   pc;
  logic [7:0]       w_reg;
  logic [7:0]       status;
  logic [SPW-1:0]   sp;
  logic [STACK_W-1:0] stack [STACK_DEPTH];

  // Register file RAM and per-entry valid bits.
  logic [7:0]          rf_mem [FILE_BYTES];
  logic [FILE_BYTES-1:0] rf_vld;
  logic [7:0]          rf_rdata;
  logic                rf_rvld;

  // Most recent write, forwarded into the execute stage.
  logic                lw_valid;
  logic [FILE_AW-1:0]  lw_addr;
  logic [7:0]          lw_data;

  // Execute stage.
  logic        ex_valid;
  logic [15:0] ir;
  logic        ex_go;
  logic        s_acc;

  // Execute results.
  logic [7:0]       fv;
  logic             rf_we;
  logic [7:0]       rf_wd;
  logic [7:0]       w_nx;
  logic [7:0]       st_nx;
  logic [PCW-1:0]   npc;
  logic             push;
  logic             pop;
  logic             fault;
  outcome_t         oc;
  logic [SPW-1:0]   sp_dec;
  logic [SPW-1:0]   sp_inc;

  assign ex_go    = ex_valid && (!m_tvalid || m_tready);
  assign s_tready = !ex_valid || ex_go;
  assign s_acc    = s_tvalid && s_tready;

  assign sp_dec = (sp == '0) ? SP_LAST : sp - 1'b1;
  assign sp_inc = (sp == SP_LAST) ? '0 : sp + 1'b1;

  always_ff @(posedge clk) begin
    if (s_acc) begin
      rf_rdata <= rf_mem[s_tdata[FILE_AW-1:0]];
      rf_rvld  <= rf_vld[s_tdata[FILE_AW-1:0]];
      ir       <= s_tdata;
    end
    if (ex_go && rf_we) begin
      rf_mem[ir[FILE_AW-1:0]] <= rf_wd;
    end
    if (ex_go && push) begin
      stack[sp] <= STACK_W'(pc + 1'b1);
    end
    if (ex_go && rf_we) begin
      lw_addr <= ir[FILE_AW-1:0];
      lw_data <= rf_wd;
    end
    if (ex_go) begin
      m_tdata <= {4'd0, oc, st_nx, w_nx, 10'(STACK_W'(npc))};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      w_reg    <= '0;
      status   <= STATUS_RESET;
      sp       <= '0;
      rf_vld   <= '0;
      lw_valid <= 1'b0;
      ex_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_acc) begin
        ex_valid <= 1'b1;
      end else if (ex_go) begin
        ex_valid <= 1'b0;
      end
      if (ex_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ex_go && !fault) begin
        pc    <= npc;
        w_reg <= w_nx;
        status <= st_nx;
        if (push) begin
          sp <= sp_inc;
        end else if (pop) begin
          sp <= sp_dec;
        end
      end
      if (ex_go && rf_we) begin
        rf_vld[ir[FILE_AW-1:0]] <= 1'b1;
        lw_valid <= 1'b1;
      end
    end
  end

  always_comb begin
    logic [13:0]    op;
    logic           d;
    logic [7:0]     lit;
    logic [7:0]     res;
    logic [7:0]     mask;
    logic [8:0]     sum;
    logic           dst;
    logic           zf;
    logic           skip;
    logic [13:0]    p1;
    logic [STACK_W-1:0] tgt;
    logic [7:0]     st;
    logic [7:0]     w;
    op   = ir[13:0];
    d    = op[7];
    lit  = op[7:0];
    res  = '0;
    sum  = '0;
    dst  = 1'b0;
    zf   = 1'b0;
    skip = 1'b0;
    push = 1'b0;
    pop  = 1'b0;
    fault = 1'b0;
    rf_we = 1'b0;
    rf_wd = '0;
    st   = status;
    w    = w_reg;
    mask = 8'd1 << op[9:7];
    p1   = 14'(pc) + 14'd1;
    tgt  = {p1[12:11], op[10:0]};
    npc  = pc + 1'b1;
    fv   = (lw_valid && lw_addr == op[FILE_AW-1:0]) ? lw_data
         : (rf_rvld ? rf_rdata : 8'd0);

    if (ir[15:14] != 2'b00) begin
      fault = 1'b1;
    end else begin
      unique case (op[13:12])
        GRP_BYTE: begin
          unique case (op[11:8])
            OP_ADD: begin
              sum = {1'b0, w_reg} + {1'b0, fv};
              res = sum[7:0];
              st[ST_DC] = ({1'b0, w_reg[3:0]} + {1'b0, fv[3:0]}) > 5'd15;
              st[ST_C]  = sum[8];
              dst = 1'b1; zf = 1'b1;
            end
            OP_SUB: begin
              res = fv - w_reg;
              st[ST_DC] = fv[3:0] >= w_reg[3:0];
              st[ST_C]  = fv >= w_reg;
              dst = 1'b1; zf = 1'b1;
            end
            OP_AND:   begin res = w_reg & fv; dst = 1'b1; zf = 1'b1; end
            OP_OR:    begin res = w_reg | fv; dst = 1'b1; zf = 1'b1; end
            OP_XOR:   begin res = w_reg ^ fv; dst = 1'b1; zf = 1'b1; end
            OP_MOVF:  begin res = fv;         dst = 1'b1; zf = 1'b1; end
            OP_COMF:  begin res = ~fv;        dst = 1'b1; zf = 1'b1; end
            OP_DECF:  begin res = fv - 8'd1;  dst = 1'b1; zf = 1'b1; end
            OP_INCF:  begin res = fv + 8'd1;  dst = 1'b1; zf = 1'b1; end
            OP_DEC_SKIP: begin
              res = fv - 8'd1; dst = 1'b1; skip = (res == 8'd0);
            end
            OP_INC_SKIP: begin
              res = fv + 8'd1; dst = 1'b1; skip = (res == 8'd0);
            end
            OP_RLF: begin
              res = {fv[6:0], status[ST_C]};
              st[ST_C] = fv[7];
              dst = 1'b1;
            end
            OP_RRF: begin
              res = {status[ST_C], fv[7:1]};
              st[ST_C] = fv[0];
              dst = 1'b1;
            end
            OP_NIB_SWAP: begin res = {fv[3:0], fv[7:4]}; dst = 1'b1; end
            OP_CLR:   begin res = 8'd0; dst = 1'b1; zf = 1'b1; end
            OP_MISC: begin
              if (d) begin
                rf_we = 1'b1;
                rf_wd = w_reg;
              end else if (op[3:0] != 4'd0) begin
                unique case (op[7:0])
                  CW_CLRWDT: begin st[ST_PD] = 1'b1; st[ST_TO] = 1'b1; end
                  CW_RETURN, CW_RETFIE: pop = 1'b1;
                  CW_SLEEP: begin st[ST_TO] = 1'b1; st[ST_PD] = 1'b0; end
                  default: fault = 1'b1;
                endcase
              end
            end
            default: fault = 1'b1;
          endcase
        end
        GRP_BIT: begin
          unique case (op[11:10])
            BK_BCF:   begin rf_we = 1'b1; rf_wd = fv & ~mask; end
            BK_BSF:   begin rf_we = 1'b1; rf_wd = fv | mask; end
            BK_BTFSC: skip = (fv & mask) == 8'd0;
            default:  skip = (fv & mask) != 8'd0;
          endcase
        end
        GRP_JUMP: begin
          push = !op[11];
          npc  = tgt[PCW-1:0];
        end
        default: begin
          if (op[11:9] == 3'b111) begin
            sum = {1'b0, w_reg} + {1'b0, lit};
            res = sum[7:0];
            st[ST_DC] = ({1'b0, w_reg[3:0]} + {1'b0, lit[3:0]}) > 5'd15;
            st[ST_C]  = sum[8];
            w = res; zf = 1'b1;
          end else if (op[11:8] == 4'h9) begin
            res = w_reg & lit; w = res; zf = 1'b1;
          end else if (op[11:8] == 4'h8) begin
            res = w_reg | lit; w = res; zf = 1'b1;
          end else if (op[11:8] == 4'hA) begin
            res = w_reg ^ lit; w = res; zf = 1'b1;
          end else if (op[11:10] == 2'b00) begin
            w = lit;
          end else if (op[11:10] == 2'b01) begin
            w = lit; pop = 1'b1;
          end else if (op[11:10] == 2'b11) begin
            res = lit - w_reg;
            st[ST_DC] = lit[3:0] >= w_reg[3:0];
            st[ST_C]  = lit >= w_reg;
            w = res; zf = 1'b1;
          end else begin
            fault = 1'b1;
          end
        end
      endcase
    end

    if (dst) begin
      if (d) begin
        rf_we = 1'b1;
        rf_wd = res;
      end else begin
        w = res;
      end
    end
    if (zf) begin
      st[ST_Z] = (res == 8'd0);
    end
    if (skip) begin
      npc = pc + 2'd2;
    end
    if (pop) begin
      npc = stack[sp_dec][PCW-1:0];
    end
    oc = OUT_EXECUTED;
    if (fault) begin
      rf_we = 1'b0;
      push  = 1'b0;
      pop   = 1'b0;
      w     = w_reg;
      st    = status;
      npc   = pc;
      oc    = OUT_FAULT;
    end else if (!st[ST_PD]) begin
      npc = pc;
      oc  = OUT_HALTED;
    end
    w_nx  = w;
    st_nx = st;
  end

  // A faulting instruction leaves W and STATUS untouched.
  a_fault_keeps_w: assert property (@(posedge clk) disable iff (rst)
    ex_go && fault |=> w_reg == $past(w_reg) && status == $past(status))
    else $error("fault changed W or STATUS");

  // A halted result holds the program counter.
  a_halt_holds_pc: assert property (@(posedge clk) disable iff (rst)
    ex_go && oc == OUT_HALTED |=> pc == $past(pc))
    else $error("halted step moved the PC");

  // A register file write by an executing instruction marks its entry valid.
  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    rf_we && !fault && ex_go |=> rf_vld[$past(ir[FILE_AW-1:0])])
    else $error("register file write not recorded");

  // With the execute stage empty the input is always ready.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !ex_valid |-> s_tready)
    else $error("input stalled with empty execute stage");

endmodule

`default_nettype wire

### bench/mcuex_checker.sv
// ----------------------------------------------------------------------------
// mcuex_checker
// Watches both channels of the execute core, runs its own model of the core
// on each accepted instruction and compares every result transaction with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module mcuex_checker #(
  parameter int unsigned PROG_WORDS  = mcuex_pkg::PROG_WORDS_DEF,
  parameter int unsigned STACK_DEPTH = mcuex_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  output int               fail_count,
  output int               pending
);
  import mcuex_pkg::*;

  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] status;
    logic [7:0] w;
    logic [9:0] npc;
  } exec_result_t;

  int unsigned pc;
  logic [7:0]  w_reg;
  logic [7:0]  st_reg;
  logic [7:0]  regs [FILE_BYTES];
  logic [12:0] ret_stack [STACK_DEPTH];
  int unsigned sp;
  exec_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [7:0] set_flag(logic [7:0] s, int unsigned b, logic on);
    s[b] = on;
    return s;
  endfunction

  task automatic execute_instruction(input logic [15:0] op);
    int unsigned npc;
    logic [6:0]  f;
    logic        d;
    logic [7:0]  fv, w, st, lit, res, wv, mask;
    logic [8:0]  sum;
    logic        dst, zf, fault, skip, wr, push, pop;
    exec_result_t r;
    npc = (pc + 1) % PROG_WORDS;
    f = op[6:0];
    d = op[7];
    fv = regs[f];
    w = w_reg;
    st = st_reg;
    lit = op[7:0];
    res = '0; wv = '0; mask = '0;
    {dst, zf, fault, skip, wr, push, pop} = '0;
    if (op[15:14] != 2'b00) begin
      fault = 1'b1;
    end else if (op[13:12] == GRP_BYTE) begin
      case (op[11:8])
        OP_ADD: begin
          sum = {1'b0, w} + {1'b0, fv}; res = sum[7:0];
          st = set_flag(st, ST_DC, ({1'b0, w[3:0]} + {1'b0, fv[3:0]}) > 5'd15);
          st = set_flag(st, ST_C, sum[8]);
          dst = 1; zf = 1;
        end
        OP_SUB: begin
          res = fv - w;
          st = set_flag(st, ST_DC, fv[3:0] >= w[3:0]);
          st = set_flag(st, ST_C, fv >= w);
          dst = 1; zf = 1;
        end
        OP_AND:   begin res = w & fv; dst = 1; zf = 1; end
        OP_OR:    begin res = w | fv; dst = 1; zf = 1; end
        OP_XOR:   begin res = w ^ fv; dst = 1; zf = 1; end
        OP_MOVF:  begin res = fv; dst = 1; zf = 1; end
        OP_COMF:  begin res = ~fv; dst = 1; zf = 1; end
        OP_DECF:  begin res = fv - 8'd1; dst = 1; zf = 1; end
        OP_INCF:  begin res = fv + 8'd1; dst = 1; zf = 1; end
        OP_DEC_SKIP: begin res = fv - 8'd1; dst = 1; skip = (res == 0); end
        OP_INC_SKIP: begin res = fv + 8'd1; dst = 1; skip = (res == 0); end
        OP_RLF: begin
          res = {fv[6:0], st_reg[ST_C]};
          st = set_flag(st, ST_C, fv[7]); dst = 1;
        end
        OP_RRF: begin
          res = {st_reg[ST_C], fv[7:1]};
          st = set_flag(st, ST_C, fv[0]); dst = 1;
        end
        OP_NIB_SWAP: begin res = {fv[3:0], fv[7:4]}; dst = 1; end
        OP_CLR:   begin res = '0; dst = 1; zf = 1; end
        default: begin
          if (d) begin
            wr = 1; wv = w;
          end else if (op[3:0] != 0) begin
            case (op[7:0])
              CW_CLRWDT: begin st[ST_PD] = 1; st[ST_TO] = 1; end
              CW_RETURN, CW_RETFIE: pop = 1;
              CW_SLEEP: begin st[ST_TO] = 1; st[ST_PD] = 0; end
              default: fault = 1;
            endcase
          end
        end
      endcase
    end else if (op[13:12] == GRP_BIT) begin
      mask = 8'd1 << op[9:7];
      case (op[11:10])
        BK_BCF:   begin wr = 1; wv = fv & ~mask; end
        BK_BSF:   begin wr = 1; wv = fv | mask; end
        BK_BTFSC: skip = (fv & mask) == 0;
        default:  skip = (fv & mask) != 0;
      endcase
    end else if (op[13:12] == GRP_JUMP) begin
      push = !op[11];
      npc = (((pc + 1) & 32'h1800) | (32'(op) & 32'h7FF)) % PROG_WORDS;
    end else begin
      if (op[11:9] == 3'b111) begin
        sum = {1'b0, w} + {1'b0, lit}; res = sum[7:0];
        st = set_flag(st, ST_DC, ({1'b0, w[3:0]} + {1'b0, lit[3:0]}) > 5'd15);
        st = set_flag(st, ST_C, sum[8]);
        w = res; zf = 1;
      end else if (op[11:8] == 4'h9) begin res = w & lit; w = res; zf = 1;
      end else if (op[11:8] == 4'h8) begin res = w | lit; w = res; zf = 1;
      end else if (op[11:8] == 4'hA) begin res = w ^ lit; w = res; zf = 1;
      end else if (op[11:10] == 2'b00) begin w = lit;
      end else if (op[11:10] == 2'b01) begin w = lit; pop = 1;
      end else if (op[11:10] == 2'b11) begin
        res = lit - w;
        st = set_flag(st, ST_DC, lit[3:0] >= w[3:0]);
        st = set_flag(st, ST_C, lit >= w);
        w = res; zf = 1;
      end else begin
        fault = 1;
      end
    end

    r.outcome = OUT_EXECUTED;
    if (fault) begin
      r.outcome = OUT_FAULT;
      npc = pc; w = w_reg; st = st_reg;
    end else begin
      if (dst) begin
        if (d) begin wr = 1; wv = res; end else w = res;
      end
      if (zf) st = set_flag(st, ST_Z, res == 0);
      if (skip) npc = (pc + 2) % PROG_WORDS;
      if (wr) regs[f] = wv;
      if (push) begin
        ret_stack[sp] = 13'((pc + 1) % PROG_WORDS);
        sp = (sp + 1) % STACK_DEPTH;
      end
      if (pop) begin
        sp = (sp + STACK_DEPTH - 1) % STACK_DEPTH;
        npc = 32'(ret_stack[sp]) % PROG_WORDS;
      end
      w_reg = w;
      st_reg = st;
      if (!st[ST_PD]) begin
        r.outcome = OUT_HALTED;
        npc = pc;
      end
      pc = npc;
    end
    r.npc = 10'(npc); r.w = w; r.status = st;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    exec_result_t got, exp_r;
    if (rst) begin
      pc = 0; w_reg = '0; st_reg = STATUS_RESET; sp = 0;
      foreach (regs[i]) regs[i] = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // The result check runs first, so a prediction made this edge is never
      // compared against a result accepted at the same edge.
      if (m_tvalid && m_tready) begin
        got = m_tdata[27:0];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result transaction %h", m_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || m_tdata[31:28] !== 4'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: npc %0d/%0d w %h/%h status %h/%h outcome %0d/%0d (exp/got)",
                       exp_r.npc, got.npc, exp_r.w, got.w, exp_r.status, got.status,
                       exp_r.outcome, got.outcome);
          end
        end
      end
      if (s_tvalid && s_tready) execute_instruction(s_tdata);
    end
  end

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random instruction streams, including call/return
// sequences kept within the written part of the return stack, into the core
// with bursty input and a stalling output, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import mcuex_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          depth_written = 0;  // stack entries known to be written
  int          call_depth = 0;

  always #1 clk = ~clk;

  midrange_mcu_instruction_execute_core dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  mcuex_checker checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .fail_count, .pending
  );

  // Output stall pattern: phases of no stall, light and heavy stalling.
  always @(negedge clk) begin
    int mode;
    mode = int'(($time / 400) % 3);
    m_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(3) != 0)
                                                 : ($urandom_range(3) == 0);
  end

  task automatic send_instruction(input logic [15:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Tracks the return stack so that a pop never reads an unwritten entry.
  function automatic logic [15:0] pick_random_word();
    logic [15:0] w;
    int kind;
    kind = $urandom_range(99);
    w = 16'($urandom_range(16'h3FFF));
    if (kind < 4) begin
      w = 16'($urandom);
      w[15:14] = 2'($urandom_range(2) + 1);
    end else if (kind < 12) begin
      w = {2'b00, 3'b100, 11'($urandom)};  // call
    end else if (kind < 20) begin
      w = ($urandom_range(1) == 0) ? {8'h00, CW_RETURN} : {6'h0D, 10'($urandom)};
    end else if (kind < 24) begin
      w = {8'h00, 8'($urandom_range(1, 127))};
    end else if (kind < 27) begin
      w = {8'h00, ($urandom_range(2) == 0) ? CW_SLEEP : CW_CLRWDT};
    end
    if (w[15:14] == 0) begin
      if (w[13:11] == 3'b100) begin
        call_depth++;
      end else if (w == {8'h00, CW_RETURN} || w == {8'h00, CW_RETFIE}
                   || w[13:10] == 4'b1101) begin
        if (call_depth == 0 && depth_written < STACK_DEPTH_DEF) w = {6'h0C, 10'($urandom)};
        else call_depth--;
      end
    end
    return w;
  endfunction

  initial begin
    logic [15:0] directed [] = '{
      16'h3000, 16'h3EFF, 16'h0780, 16'h0700, 16'h0201, 16'h3C00, 16'h3CFF,
      16'h3901, 16'h3880, 16'h3A55, 16'h0085, 16'h0D85, 16'h0C85, 16'h0E85,
      16'h0905, 16'h0A85, 16'h0B85, 16'h0F85, 16'h0185, 16'h0100, 16'h0485,
      16'h0585, 16'h0605, 16'h0805, 16'h0305, 16'h1385, 16'h1785, 16'h1B85,
      16'h1F85, 16'h2155, 16'h3455, 16'h2BFF, 16'h0063, 16'h0A05, 16'h0064,
      16'h0001, 16'h3B00, 16'hC000, 16'hFFFF, 16'h4000, 16'h0000
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_instruction(directed[i]);
    for (int n = 0; n < 700; n++) begin
      send_instruction(pick_random_word());
      if (depth_written < STACK_DEPTH_DEF && call_depth > depth_written)
        depth_written = call_depth;
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
